>>> rtl/ksdh_pkg.sv
// ----------------------------------------------------------------------------
// ksdh_pkg
// Shared types and constants for the keypad scanner with debounce, hold
// repeat and event queue.
// ----------------------------------------------------------------------------
package ksdh_pkg;

    localparam int unsigned LEVEL_W   = 6;   // key level bits on the input word
    localparam int unsigned CNT_W     = 8;   // press counter width
    localparam int unsigned KEY_W     = 4;   // key index width in an event
    localparam int unsigned KIND_W    = 2;   // event kind width
    localparam int unsigned CFG_IDX_W = 1;   // configuration register index

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'b1;

    localparam logic [CNT_W-1:0] DEBOUNCE_RST = 8'd1;
    localparam logic [CNT_W-1:0] HOLD_RST     = 8'd50;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_HOLD    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_PART  = 2'd1,
        FILL_FULL  = 2'd2
    } t_fill;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RD,
        S_RD_DATA,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;    // latch the input word, reset key index and result
        logic step_key;   // update one key's counter, queue its event
        logic pop;        // read the queue head, advance it
        logic take_rdata; // latch the popped entry into the result
        logic load_out;   // move the result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_key;
        logic empty;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/ksdh_ram.sv
// ----------------------------------------------------------------------------
// ksdh_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ksdh_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ksdh_ctrl.sv
// ----------------------------------------------------------------------------
// ksdh_ctrl
// Sequencer: accepts one word, walks the keys one per cycle on a scan tick or
// runs the queue read on a read request, then hands the result on.
// ----------------------------------------------------------------------------
module ksdh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_mode,
    output logic            o_in_stall,
    input  ksdh_pkg::t_stat i_stat,
    output ksdh_pkg::t_cmd  o_cmd
);

    ksdh_pkg::t_state r_state;
    ksdh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ksdh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ksdh_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_in_mode) begin
                        n_state = ksdh_pkg::S_SCAN;
                    end else if (i_stat.empty) begin
                        n_state = ksdh_pkg::S_DONE;
                    end else begin
                        n_state = ksdh_pkg::S_RD;
                    end
                end
            end
            ksdh_pkg::S_SCAN: begin
                if (i_stat.last_key) begin
                    n_state = ksdh_pkg::S_DONE;
                end
            end
            ksdh_pkg::S_RD:      n_state = ksdh_pkg::S_RD_DATA;
            ksdh_pkg::S_RD_DATA: n_state = ksdh_pkg::S_DONE;
            ksdh_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = ksdh_pkg::S_IDLE;
                end
            end
            default: n_state = ksdh_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ksdh_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ksdh_pkg::S_SCAN:    o_cmd.step_key   = 1'b1;
            ksdh_pkg::S_RD:      o_cmd.pop        = 1'b1;
            ksdh_pkg::S_RD_DATA: o_cmd.take_rdata = 1'b1;
            ksdh_pkg::S_DONE:    o_cmd.load_out   = i_stat.out_free;
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> rtl/ksdh_dp.sv
// ----------------------------------------------------------------------------
// ksdh_dp
// Datapath: configuration registers, per-key press counters, event queue
// pointers and storage, result and output registers.
// ----------------------------------------------------------------------------
module ksdh_dp #(
    parameter int unsigned NUM_KEYS    = 6,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [ksdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ksdh_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic [ksdh_pkg::LEVEL_W-1:0]      i_in_key_levels,
    input  logic                              i_out_stall,
    input  ksdh_pkg::t_cmd                    i_cmd,
    output ksdh_pkg::t_stat                   o_stat,
    output logic                              o_out_valid,
    output logic                              o_event_valid,
    output logic [ksdh_pkg::KEY_W-1:0]        o_event_key,
    output logic [ksdh_pkg::KIND_W-1:0]       o_event_kind,
    output logic                              o_queue_empty,
    output logic                              o_queue_full
);

    localparam int unsigned KIDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned ENTRY_W = ksdh_pkg::KEY_W + ksdh_pkg::KIND_W;
    localparam int unsigned CNT_W   = ksdh_pkg::CNT_W;

    // configuration
    logic [CNT_W-1:0] r_deb;
    logic [CNT_W-1:0] r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb  <= ksdh_pkg::DEBOUNCE_RST;
            r_hold <= ksdh_pkg::HOLD_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ksdh_pkg::CFG_DEBOUNCE) begin
                r_deb <= i_cfg_data;
            end
            if (i_cfg_index == ksdh_pkg::CFG_HOLD) begin
                r_hold <= i_cfg_data;
            end
        end
    end

    // captured word and key walk
    logic [ksdh_pkg::LEVEL_W-1:0] r_levels;
    logic [KIDX_W-1:0]            r_key_idx;
    logic [NUM_KEYS-1:0]          w_down_vec;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_levels <= i_in_key_levels;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_idx <= '0;
        end else if (i_cmd.capture) begin
            r_key_idx <= '0;
        end else if (i_cmd.step_key) begin
            r_key_idx <= r_key_idx + KIDX_W'(1);
        end
    end

    // keys beyond the input word always read as released
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lvl
        if (k < ksdh_pkg::LEVEL_W) begin : g_in
            assign w_down_vec[k] = r_levels[k];
        end else begin : g_none
            assign w_down_vec[k] = 1'b0;
        end
    end

    // press counter update for the current key
    logic [CNT_W-1:0] r_cnt [NUM_KEYS];
    logic [CNT_W-1:0] w_cnt_cur;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [CNT_W:0]   w_press_mark;
    logic [CNT_W:0]   w_hold_mark;
    logic [CNT_W-1:0] n_cnt;
    logic             w_event;
    ksdh_pkg::t_kind  w_kind;
    logic             w_down;

    assign w_down       = w_down_vec[r_key_idx];
    assign w_cnt_cur    = r_cnt[r_key_idx];
    assign w_cnt_inc    = w_cnt_cur + CNT_W'(1);
    assign w_press_mark = {1'b0, r_deb} + (CNT_W+1)'(1);
    assign w_hold_mark  = {1'b0, r_hold} + (CNT_W+1)'(1);

    always_comb begin
        n_cnt   = w_cnt_inc;
        w_event = 1'b0;
        w_kind  = ksdh_pkg::KIND_PRESS;
        if (w_down) begin
            if ({1'b0, w_cnt_inc} < w_press_mark) begin
                n_cnt = w_cnt_inc;
            end else if ({1'b0, w_cnt_inc} == w_press_mark) begin
                w_event = 1'b1;
            end else if ({1'b0, w_cnt_inc} < w_hold_mark) begin
                n_cnt = w_cnt_inc;
            end else if ({1'b0, w_cnt_inc} == w_hold_mark) begin
                // repeat: drop back to the press mark
                w_event = 1'b1;
                w_kind  = ksdh_pkg::KIND_HOLD;
                n_cnt   = w_press_mark[CNT_W-1:0];
            end else begin
                n_cnt = w_press_mark[CNT_W-1:0];
            end
        end else begin
            w_event = (w_cnt_cur > r_deb);
            w_kind  = ksdh_pkg::KIND_RELEASE;
            n_cnt   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.step_key) begin
            r_cnt[r_key_idx] <= n_cnt;
        end
    end

    // event queue
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    ksdh_pkg::t_fill    r_fill;
    logic [PTR_W-1:0]   w_head_nx;
    logic [PTR_W-1:0]   w_tail_nx;
    logic               w_we;
    logic [ENTRY_W-1:0] w_wdata;
    logic [ENTRY_W-1:0] w_rdata;

    assign w_head_nx = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);
    assign w_tail_nx = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + PTR_W'(1);
    // drop the event when the queue is full
    assign w_we      = i_cmd.step_key && w_event && (r_fill != ksdh_pkg::FILL_FULL);
    assign w_wdata   = {ksdh_pkg::KEY_W'(r_key_idx), w_kind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= ksdh_pkg::FILL_EMPTY;
        end else if (w_we) begin
            r_tail <= w_tail_nx;
            r_fill <= (w_tail_nx == r_head) ? ksdh_pkg::FILL_FULL : ksdh_pkg::FILL_PART;
        end else if (i_cmd.pop) begin
            r_head <= w_head_nx;
            r_fill <= (w_head_nx == r_tail) ? ksdh_pkg::FILL_EMPTY : ksdh_pkg::FILL_PART;
        end
    end

    ksdh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (w_wdata),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    // result of the current item
    logic                        r_evt_valid;
    logic [ksdh_pkg::KEY_W-1:0]  r_evt_key;
    logic [ksdh_pkg::KIND_W-1:0] r_evt_kind;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_evt_valid <= 1'b0;
            r_evt_key   <= '0;
            r_evt_kind  <= '0;
        end else if (i_cmd.take_rdata) begin
            r_evt_valid <= 1'b1;
            r_evt_key   <= w_rdata[ENTRY_W-1:ksdh_pkg::KIND_W];
            r_evt_kind  <= w_rdata[ksdh_pkg::KIND_W-1:0];
        end
    end

    // output register
    logic                        r_out_valid;
    logic                        r_out_evt_valid;
    logic [ksdh_pkg::KEY_W-1:0]  r_out_key;
    logic [ksdh_pkg::KIND_W-1:0] r_out_kind;
    logic                        r_out_empty;
    logic                        r_out_full;
    logic                        w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_evt_valid <= r_evt_valid;
            r_out_key       <= r_evt_key;
            r_out_kind      <= r_evt_kind;
            r_out_empty     <= (r_fill == ksdh_pkg::FILL_EMPTY);
            r_out_full      <= (r_fill == ksdh_pkg::FILL_FULL);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_out_evt_valid;
    assign o_event_key   = r_out_key;
    assign o_event_kind  = r_out_kind;
    assign o_queue_empty = r_out_empty;
    assign o_queue_full  = r_out_full;

    assign o_stat.last_key = (r_key_idx == KIDX_W'(NUM_KEYS - 1));
    assign o_stat.empty    = (r_fill == ksdh_pkg::FILL_EMPTY);
    assign o_stat.out_free = w_out_free;

`ifndef NO_ASSERTIONS
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == ksdh_pkg::FILL_FULL) |-> (r_head == r_tail))
        else $error("queue full but pointers differ");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == ksdh_pkg::FILL_EMPTY) |-> (r_head == r_tail))
        else $error("queue empty but pointers differ");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_fill != ksdh_pkg::FILL_EMPTY))
        else $error("pop on an empty queue");

    a_pop_leaves_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> (r_fill != ksdh_pkg::FILL_FULL))
        else $error("queue full after a pop");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> w_out_free)
        else $error("output register overwritten while held");
`endif

endmodule

>>> rtl/key_scan_debounce_hold_fifo_unit.sv
// ----------------------------------------------------------------------------
// key_scan_debounce_hold_fifo_unit
// Keypad scanner with per-key debounce, repeating hold events and an event
// queue read one event per request.
// ----------------------------------------------------------------------------
// A scan tick walks the keys in turn in the scan state, one key per cycle,
// and no new word is taken until the walk and the hand-over are done, since
// each key shares the one counter update and the single write port of the
// queue RAM. A read of a pending event passes the pop and read-data states,
// set by the registered read of the queue RAM; a read of an empty queue goes
// straight to the hand-over. The input is taken while an earlier result still
// waits in the output register, and only the final hand-over waits for that
// register to free. Configuration writes are always accepted and must be made while the block is idle.
module key_scan_debounce_hold_fifo_unit #(
    parameter int unsigned NUM_KEYS    = 6,
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ksdh_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ksdh_pkg::CNT_W-1:0]        i_cfg_data,
    // input words
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_in_mode,
    input  logic [ksdh_pkg::LEVEL_W-1:0]      i_in_key_levels,
    // result words
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_event_valid,
    output logic [ksdh_pkg::KEY_W-1:0]        o_event_key,
    output logic [ksdh_pkg::KIND_W-1:0]       o_event_kind,
    output logic                              o_queue_empty,
    output logic                              o_queue_full
);

    ksdh_pkg::t_cmd  w_cmd;
    ksdh_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    ksdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_mode),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ksdh_dp #(
        .NUM_KEYS    (NUM_KEYS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_key_levels (i_in_key_levels),
        .i_out_stall     (i_out_stall),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_event_valid   (o_event_valid),
        .o_event_key     (o_event_key),
        .o_event_kind    (o_event_kind),
        .o_queue_empty   (o_queue_empty),
        .o_queue_full    (o_queue_full)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keypad scanner with debounce, hold repeat and
// event queue: a short table of directed words, then phases of random key
// activity under several debounce and hold settings, each result word held
// to its table word if typed, else a behavioural model of counters and queue.
// ----------------------------------------------------------------------------
module tb_top;
    import ksdh_pkg::*;

    localparam int NKEYS      = 6;
    localparam int QDEPTH     = 16;
    localparam int WDOG_LIMIT = 1000;
    localparam int SETTLE     = 20;
    localparam int RAND_PHASE = 8;
    localparam int NPHASES    = 10;

    localparam bit MODE_SCAN = 1'b0;
    localparam bit MODE_READ = 1'b1;

    typedef struct packed {
        logic                ev_valid;
        logic [KEY_W-1:0]    key;
        t_kind               kind;
        logic                empty;
        logic                full;
    } t_event_word;

    typedef struct {
        bit                  mode;
        logic [LEVEL_W-1:0]  levels;
        bit                  typed;
        t_event_word         word;
    } t_dir_row;

    typedef struct {
        logic [CNT_W-1:0]    deb;
        logic [CNT_W-1:0]    hold;
        int                  items;
        int                  read_pct;
        int                  flip_pm;
        int                  noise_pct;
        bit                  idle;
    } t_phase;

    localparam t_event_word W_QUIET_EMPTY = '{1'b0, 4'd0, KIND_PRESS, 1'b1, 1'b0};
    localparam t_event_word W_QUIET       = '{1'b0, 4'd0, KIND_PRESS, 1'b0, 1'b0};
    localparam t_event_word W_QUIET_FULL  = '{1'b0, 4'd0, KIND_PRESS, 1'b0, 1'b1};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CNT_W-1:0]      i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_in_mode;
    logic [LEVEL_W-1:0]    i_in_key_levels;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_event_valid;
    logic [KEY_W-1:0]      o_event_key;
    logic [KIND_W-1:0]     o_event_kind;
    logic                  o_queue_empty;
    logic                  o_queue_full;

    key_scan_debounce_hold_fifo_unit #(
        .NUM_KEYS    (NKEYS),
        .QUEUE_DEPTH (QDEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_mode       (i_in_mode),
        .i_in_key_levels (i_in_key_levels),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_valid   (o_event_valid),
        .o_event_key     (o_event_key),
        .o_event_kind    (o_event_kind),
        .o_queue_empty   (o_queue_empty),
        .o_queue_full    (o_queue_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor state
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  debounce_reg;
    logic [CNT_W-1:0]  hold_reg;
    logic [CNT_W-1:0]  press_cnt   [NKEYS];
    logic [KEY_W-1:0]  ev_key_mem  [QDEPTH];
    t_kind             ev_kind_mem [QDEPTH];
    int unsigned       ev_head;
    int unsigned       ev_tail;
    t_fill             ev_fill;

    t_event_word       pending_words [$];
    t_dir_row          dir_rows [$];
    t_phase            phases [NPHASES];
    int                err_count   = 0;
    int                quiet_cycles = 0;
    bit                idle_on     = 1'b1;
    int                stall_left  = 0;

    function automatic void queue_event(int unsigned key, t_kind kind);
        if (ev_fill == FILL_FULL)
            return;     // drop: queue full
        ev_key_mem[ev_tail]  = KEY_W'(key);
        ev_kind_mem[ev_tail] = kind;
        ev_tail = (ev_tail + 1) % QDEPTH;
        ev_fill = (ev_tail == ev_head) ? FILL_FULL : FILL_PART;
    endfunction

    function automatic t_event_word next_event_word(bit mode, logic [LEVEL_W-1:0] levels);
        t_event_word     w;
        logic [CNT_W:0]  press_mark;
        logic [CNT_W:0]  hold_mark;
        logic [CNT_W:0]  c9;
        logic [CNT_W-1:0] c;
        w = '0;
        press_mark = {1'b0, debounce_reg} + 1'b1;
        hold_mark  = {1'b0, hold_reg} + 1'b1;
        if (mode == MODE_SCAN) begin
            for (int k = 0; k < NKEYS; k++) begin
                if (levels[k]) begin
                    c = press_cnt[k] + 1'b1;
                    press_cnt[k] = c;
                    c9 = {1'b0, c};
                    if (c9 == press_mark) begin
                        queue_event(k, KIND_PRESS);
                    end else if (c9 > press_mark) begin
                        // past the press mark: repeat holds from press_mark
                        if (c9 == hold_mark) begin
                            queue_event(k, KIND_HOLD);
                            press_cnt[k] = press_mark[CNT_W-1:0];
                        end else if (c9 > hold_mark) begin
                            press_cnt[k] = press_mark[CNT_W-1:0];
                        end
                    end
                end else begin
                    if (press_cnt[k] > debounce_reg)
                        queue_event(k, KIND_RELEASE);
                    press_cnt[k] = '0;
                end
            end
        end else if (ev_fill != FILL_EMPTY) begin
            w.ev_valid = 1'b1;
            w.key      = ev_key_mem[ev_head];
            w.kind     = ev_kind_mem[ev_head];
            ev_head = (ev_head + 1) % QDEPTH;
            ev_fill = (ev_head == ev_tail) ? FILL_EMPTY : FILL_PART;
        end
        w.empty = (ev_fill == FILL_EMPTY);
        w.full  = (ev_fill == FILL_FULL);
        return w;
    endfunction

    function automatic void add_row(bit mode, logic [LEVEL_W-1:0] lv, bit typed,
                                    t_event_word w);
        dir_rows.push_back('{mode, lv, typed, w});
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_word(bit mode, logic [LEVEL_W-1:0] lv, bit typed,
                             t_event_word typed_w);
        t_event_word w;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_in_mode       <= mode;
        i_in_key_levels <= lv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        w = next_event_word(mode, lv);
        pending_words.push_back(typed ? typed_w : w);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_DEBOUNCE)
            debounce_reg = data;
        else
            hold_reg = data;
        @(negedge i_clk);
    endtask

    // result side back-pressure in short bursts
    always @(negedge i_clk) begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 4);
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_event_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                $error("result word arrived with nothing pending");
                err_count++;
            end else begin
                exp_w = pending_words.pop_front();
                if (o_event_valid !== exp_w.ev_valid) begin
                    $error("event_valid: expected %0d, got %0d", exp_w.ev_valid, o_event_valid);
                    err_count++;
                end
                if (o_event_key !== exp_w.key) begin
                    $error("event_key: expected %0d, got %0d", exp_w.key, o_event_key);
                    err_count++;
                end
                if (o_event_kind !== exp_w.kind) begin
                    $error("event_kind: expected %0d, got %0d", exp_w.kind, o_event_kind);
                    err_count++;
                end
                if (o_queue_empty !== exp_w.empty) begin
                    $error("queue_empty: expected %0d, got %0d", exp_w.empty, o_queue_empty);
                    err_count++;
                end
                if (o_queue_full !== exp_w.full) begin
                    $error("queue_full: expected %0d, got %0d", exp_w.full, o_queue_full);
                    err_count++;
                end
            end
        end
    end

    // watchdog: no word moving on any channel for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("** key_scan_debounce_hold_fifo_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_phase              ph;
        logic [LEVEL_W-1:0]  held;
        logic [LEVEL_W-1:0]  lv;
        bit                  mode;

        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_in_mode       = MODE_SCAN;
        i_in_key_levels = '0;

        debounce_reg = DEBOUNCE_RST;
        hold_reg     = HOLD_RST;
        for (int k = 0; k < NKEYS; k++)
            press_cnt[k] = '0;
        ev_head = 0;
        ev_tail = 0;
        ev_fill = FILL_EMPTY;

        // directed words under the reset settings (debounce 1, hold 50)
        add_row(MODE_READ, 6'h00, 1'b1, W_QUIET_EMPTY);   // read of an empty queue
        add_row(MODE_SCAN, 6'h00, 1'b1, W_QUIET_EMPTY);
        add_row(MODE_SCAN, 6'h3F, 1'b1, W_QUIET_EMPTY);   // still debouncing
        add_row(MODE_SCAN, 6'h3F, 1'b1, W_QUIET);         // six presses
        for (int k = 0; k < NKEYS; k++)
            add_row(MODE_READ, 6'h3F, 1'b1,
                    '{1'b1, KEY_W'(k), KIND_PRESS, (k == NKEYS - 1), 1'b0});
        add_row(MODE_READ, 6'h2A, 1'b1, W_QUIET_EMPTY);
        add_row(MODE_SCAN, 6'h00, 1'b1, W_QUIET);         // six releases
        add_row(MODE_SCAN, 6'h3F, 1'b0, W_QUIET);
        add_row(MODE_SCAN, 6'h3F, 1'b0, W_QUIET);
        add_row(MODE_SCAN, 6'h15, 1'b0, W_QUIET);
        add_row(MODE_SCAN, 6'h3F, 1'b0, W_QUIET);
        add_row(MODE_SCAN, 6'h3F, 1'b1, W_QUIET_FULL);    // fills, drops the rest
        add_row(MODE_READ, 6'h15, 1'b1, '{1'b1, 4'd0, KIND_RELEASE, 1'b0, 1'b0});
        add_row(MODE_SCAN, 6'h3F, 1'b0, W_QUIET);
        add_row(MODE_SCAN, 6'h2A, 1'b0, W_QUIET);         // fills again
        repeat (5) add_row(MODE_READ, 6'h00, 1'b0, W_QUIET);

        phases = '{
            '{8'd0,   8'd1,   150, 50, 100, 10, 1'b1},
            '{8'd3,   8'd8,   200, 45,  60, 10, 1'b1},
            '{8'd5,   8'd5,   150, 45,  60, 10, 1'b1},   // hold not above debounce
            '{8'd10,  8'd4,   150, 40,  30, 10, 1'b1},
            '{8'd253, 8'd254, 400, 20,   1,  0, 1'b1},
            '{8'd255, 8'd50,   80, 40,  50, 20, 1'b1},   // never any event
            '{8'd2,   8'd255, 400, 20,   1,  0, 1'b1},   // counter wraps
            '{8'd0,   8'd254, 150, 50,  50, 10, 1'b1},
            '{8'd0,   8'd0,   200, 45,  40, 15, 1'b1},   // settings drawn at run time
            '{8'd1,   8'd50,  100, 45,  40, 10, 1'b0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r])
            send_word(dir_rows[r].mode, dir_rows[r].levels, dir_rows[r].typed,
                      dir_rows[r].word);
        i_in_valid <= 1'b0;

        for (int p = 0; p < NPHASES; p++) begin
            ph = phases[p];
            if (p == RAND_PHASE) begin
                ph.deb  = CNT_W'($urandom_range(0, 30));
                ph.hold = CNT_W'($urandom_range(1, 60));
            end
            // hold until the block is idle before touching the registers
            while (pending_words.size() != 0) @(posedge i_clk);
            repeat (10) @(negedge i_clk);
            idle_on = ph.idle;
            write_reg(CFG_DEBOUNCE, ph.deb);
            write_reg(CFG_HOLD, ph.hold);
            i_cfg_valid <= 1'b0;

            // long thresholds need keys held from the start
            held = (ph.flip_pm < 10) ? 6'h3F : LEVEL_W'($urandom_range(0, 63));
            for (int n = 0; n < ph.items; n++) begin
                lv = LEVEL_W'($urandom_range(0, 63));
                if ($urandom_range(0, 99) < ph.read_pct) begin
                    mode = MODE_READ;
                end else begin
                    mode = MODE_SCAN;
                    if ($urandom_range(0, 99) >= ph.noise_pct) begin
                        for (int k = 0; k < LEVEL_W; k++)
                            if ($urandom_range(0, 999) < ph.flip_pm)
                                held[k] = ~held[k];
                        lv = held;
                    end
                end
                send_word(mode, lv, 1'b0, W_QUIET);
            end
            i_in_valid <= 1'b0;
        end

        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0 && pending_words.size() == 0) begin
            $display("** key_scan_debounce_hold_fifo_unit: PASSED **");
        end else begin
            if (pending_words.size() != 0)
                $error("%0d result words never arrived", pending_words.size());
            $display("** key_scan_debounce_hold_fifo_unit: FAILED **");
        end
        $finish;
    end

endmodule
